// File: design/lps_pkg.sv
// package for the line pixel stepper: widths, stream packing, command word
// type shared by the front end, the command queue and the stepping back end
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    localparam int CoordBits  = 12;
    localparam int ErrBits    = CoordBits + 1;
    localparam int ChanBits   = 8;
    localparam int ColourBits = 3 * ChanBits;

    localparam int SDataUsed = 4 * CoordBits + ColourBits;
    localparam int SDataBits = ((SDataUsed + 7) / 8) * 8;
    localparam int MDataUsed = 2 * CoordBits + ColourBits;
    localparam int MDataBits = ((MDataUsed + 7) / 8) * 8;

    localparam int QueueDepth = 2;
    localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntBits   = $clog2(QueueDepth + 1);

    typedef logic [CoordBits-1:0]  t_coord;
    typedef logic [ErrBits-1:0]    t_err;
    typedef logic [ColourBits-1:0] t_colour;

    typedef enum logic {
        LPS_OP_START = 1'b0,
        LPS_OP_TICK  = 1'b1
    } t_lps_op;

    // decoded word handed from the front end to the back end
    typedef struct packed {
        t_lps_op op;
        t_coord  start_x;
        t_coord  start_y;
        t_coord  abs_dx;
        t_coord  abs_dy;
        logic    step_x_neg;
        logic    step_y_neg;
        logic    x_major;
        t_err    error_init;
        t_err    steps;
        t_colour colour;
    } t_lps_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } t_lps_qstat;

    function automatic t_coord lps_move(input t_coord c, input logic neg);
        return neg ? t_coord'(c - 1'b1) : t_coord'(c + 1'b1);
    endfunction

endpackage

`default_nettype wire

// File: design/lps_front.sv
// front end: unpacks an input word and classifies it; a start word has its
// deltas, step signs, major axis and accumulator seed worked out here
// depends on lps_pkg
`timescale 1ns / 1ps
`default_nettype none

module lps_front (
    input  wire logic [lps_pkg::SDataBits-1:0] i_s_tdata,
    input  wire logic                          i_s_tuser,
    output lps_pkg::t_lps_cmd                  o_cmd
);
    import lps_pkg::*;

    t_coord x1, y1, x2, y2, adx, ady, major;
    logic   xmaj;

    always_comb begin
        x1 = i_s_tdata[CoordBits-1:0];
        y1 = i_s_tdata[2*CoordBits-1:CoordBits];
        x2 = i_s_tdata[3*CoordBits-1:2*CoordBits];
        y2 = i_s_tdata[4*CoordBits-1:3*CoordBits];
        adx = (x1 >= x2) ? t_coord'(x1 - x2) : t_coord'(x2 - x1);
        ady = (y1 >= y2) ? t_coord'(y1 - y2) : t_coord'(y2 - y1);
        xmaj = adx >= ady;
        major = xmaj ? adx : ady;

        o_cmd.op         = t_lps_op'(i_s_tuser);
        o_cmd.start_x    = x1;
        o_cmd.start_y    = y1;
        o_cmd.abs_dx     = adx;
        o_cmd.abs_dy     = ady;
        o_cmd.step_x_neg = !(x2 > x1);
        o_cmd.step_y_neg = !(y2 > y1);
        o_cmd.x_major    = xmaj;
        o_cmd.error_init = t_err'(major >> 1);
        o_cmd.steps      = t_err'(major);
        // red sits in the top byte of the colour word
        o_cmd.colour     = {i_s_tdata[4*CoordBits +: ChanBits],
                            i_s_tdata[4*CoordBits+ChanBits +: ChanBits],
                            i_s_tdata[4*CoordBits+2*ChanBits +: ChanBits]};
    end

endmodule

`default_nettype wire

// File: design/lps_queue.sv
// short command queue between the front end and the back end
// depends on lps_pkg
`timescale 1ns / 1ps
`default_nettype none

module lps_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  lps_pkg::t_lps_cmd i_cmd,
    input  wire logic         i_pop,
    output lps_pkg::t_lps_cmd o_cmd,
    output lps_pkg::t_lps_qstat o_stat
);
    import lps_pkg::*;

    t_lps_cmd              r_mem [QueueDepth];
    logic [QPtrBits-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPtrBits-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCntBits-1:0]   r_count, n_count;
    logic                  do_push, do_pop;

    always_comb begin
        do_push = i_push && (r_count != QCntBits'(QueueDepth));
        do_pop  = i_pop && (r_count != '0);
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPtrBits'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPtrBits'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd            = r_mem[r_rd_ptr];
    assign o_stat.not_full  = r_count != QCntBits'(QueueDepth);
    assign o_stat.not_empty = r_count != '0;

endmodule

`default_nettype wire

// File: design/lps_back.sv
// back end: holds the line state, runs one stepping pass per tick word and
// keeps the pixel in an output register until the receiver takes it
// depends on lps_pkg
`timescale 1ns / 1ps
`default_nettype none

module lps_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  lps_pkg::t_lps_cmd                  i_cmd,
    input  lps_pkg::t_lps_qstat                i_stat,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [lps_pkg::MDataBits-1:0]      o_m_tdata,
    output logic                               o_m_tlast
);
    import lps_pkg::*;

    logic    r_active, n_active;
    t_coord  r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    t_coord  r_abs_dx, n_abs_dx, r_abs_dy, n_abs_dy;
    logic    r_sx_neg, n_sx_neg, r_sy_neg, n_sy_neg, r_x_major, n_x_major;
    t_err    r_err, n_err, r_steps, n_steps;
    t_colour r_colour, n_colour;

    logic    r_out_valid, n_out_valid;
    t_coord  r_px, n_px, r_py, n_py;
    t_colour r_pcol, n_pcol;
    logic    r_plast, n_plast;

    t_coord  major, minor, stx, sty;
    t_err    sum, err_step, steps_dec;
    logic    carry;

    always_comb begin
        o_pop = i_stat.not_empty && (!r_out_valid || i_m_tready);

        major = r_x_major ? r_abs_dx : r_abs_dy;
        minor = r_x_major ? r_abs_dy : r_abs_dx;
        sum = r_err + t_err'(minor);
        carry = sum >= t_err'(major);
        err_step = carry ? t_err'(sum - t_err'(major)) : sum;
        stx = r_cur_x;
        sty = r_cur_y;
        if (carry) begin
            if (r_x_major) begin
                sty = lps_move(r_cur_y, r_sy_neg);
            end else begin
                stx = lps_move(r_cur_x, r_sx_neg);
            end
        end
        if (r_x_major) begin
            stx = lps_move(stx, r_sx_neg);
        end else begin
            sty = lps_move(sty, r_sy_neg);
        end
        steps_dec = r_steps - 1'b1;

        n_active  = r_active;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_abs_dx  = r_abs_dx;
        n_abs_dy  = r_abs_dy;
        n_sx_neg  = r_sx_neg;
        n_sy_neg  = r_sy_neg;
        n_x_major = r_x_major;
        n_err     = r_err;
        n_steps   = r_steps;
        n_colour  = r_colour;

        n_out_valid = r_out_valid && !i_m_tready;
        n_px    = r_px;
        n_py    = r_py;
        n_pcol  = r_pcol;
        n_plast = r_plast;

        if (o_pop) begin
            unique case (i_cmd.op)
                LPS_OP_START: begin
                    n_active  = i_cmd.steps != '0;
                    n_cur_x   = i_cmd.start_x;
                    n_cur_y   = i_cmd.start_y;
                    n_abs_dx  = i_cmd.abs_dx;
                    n_abs_dy  = i_cmd.abs_dy;
                    n_sx_neg  = i_cmd.step_x_neg;
                    n_sy_neg  = i_cmd.step_y_neg;
                    n_x_major = i_cmd.x_major;
                    n_err     = i_cmd.error_init;
                    n_steps   = i_cmd.steps;
                    n_colour  = i_cmd.colour;
                end
                LPS_OP_TICK: begin
                    if (r_active) begin
                        n_cur_x  = stx;
                        n_cur_y  = sty;
                        n_err    = err_step;
                        n_steps  = steps_dec;
                        n_active = steps_dec != '0;
                        n_out_valid = 1'b1;
                        n_px    = stx;
                        n_py    = sty;
                        n_pcol  = r_colour;
                        n_plast = steps_dec == '0;
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x   <= n_cur_x;
        r_cur_y   <= n_cur_y;
        r_abs_dx  <= n_abs_dx;
        r_abs_dy  <= n_abs_dy;
        r_sx_neg  <= n_sx_neg;
        r_sy_neg  <= n_sy_neg;
        r_x_major <= n_x_major;
        r_err     <= n_err;
        r_steps   <= n_steps;
        r_colour  <= n_colour;
        r_px      <= n_px;
        r_py      <= n_py;
        r_pcol    <= n_pcol;
        r_plast   <= n_plast;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = MDataBits'({r_pcol[ChanBits-1:0],
                                    r_pcol[2*ChanBits-1:ChanBits],
                                    r_pcol[3*ChanBits-1:2*ChanBits],
                                    r_py, r_px});
    assign o_m_tlast  = r_plast;

endmodule

`default_nettype wire

// File: design/line_pixel_stepper.sv
// line pixel stepper top level: front end, command queue, stepping back end
// depends on lps_pkg, lps_front, lps_queue, lps_back
//
// usage
//   slave stream: tuser = 0 starts a line, tuser = 1 asks for the next pixel.
//   a start word carries both endpoints and the colour; it gives no pixel and
//   replaces any line in progress. the start point is never drawn, so a line
//   whose endpoints match gives nothing. a tick with no line gives nothing.
//   master stream: one word per tick of an active line, tlast on the end point.
//   a tick passes through the two-entry queue and then the output register.
//   throughput: one word per cycle in either direction while the receiver keeps
//   tready high, set by the single step of the error accumulator in the back end.
//   stall: the output register holds its pixel; the queue takes up to two
//   more words, then slave tready falls until the receiver takes the pixel.
//   reset: synchronous, clears the queue, the line and the output register.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_stepper (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
    input  wire logic [lps_pkg::SDataBits-1:0] i_s_tdata,
    // op
    input  wire logic                          i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out
    output logic [lps_pkg::MDataBits-1:0]      o_m_tdata,
    output logic                               o_m_tlast
);
    import lps_pkg::*;

    t_lps_cmd   front_cmd, head_cmd;
    t_lps_qstat qstat;
    logic       pop;

    lps_front u_front (
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_cmd     (front_cmd)
    );

    lps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    lps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_stat     (qstat),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready = qstat.not_full;

endmodule

`default_nettype wire

// File: design/lps_checker.sv
// port-level checks for the line pixel stepper, bound to the top level
// depends on lps_pkg and line_pixel_stepper
`timescale 1ns / 1ps
`default_nettype none

module lps_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          i_s_tuser,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [lps_pkg::MDataBits-1:0] o_m_tdata,
    input wire logic                          o_m_tlast
);

    // a stalled pixel stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("pixel changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("pixel valid after reset");

    // the queue only fills up behind a pixel waiting at the output
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no pixel pending");

    // a start word never produces a pixel in its place: an empty output with an
    // empty queue ahead stays empty in the cycle after a lone start word
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && o_s_tready && i_s_tvalid && !i_s_tuser &&
            $past(!i_s_tvalid) && $past(!o_m_tvalid) && $past(i_rst_n) |=> !o_m_tvalid)
        else $error("pixel appeared after a start word");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (.*);

`default_nettype wire

// File: test/line_pixel_stepper_tb.sv
// self-checking bench for line_pixel_stepper: random and directed line words in,
// every pixel checked against a line tracer kept in step with the accepted words
// depends on lps_pkg and line_pixel_stepper
`timescale 1ns / 1ps

module line_pixel_stepper_tb;
    import lps_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct {
        t_lps_op      op;
        t_coord       sx;
        t_coord       sy;
        t_coord       ex;
        t_coord       ey;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
    } t_line_word;

    typedef struct {
        t_coord     x;
        t_coord     y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       is_end;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
    logic [SDataBits-1:0] i_s_tdata = '0;
    // op
    logic                 i_s_tuser = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // pixel_x, pixel_y, red_out, green_out, blue_out
    logic [MDataBits-1:0] o_m_tdata;
    logic                 o_m_tlast;

    line_pixel_stepper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    t_line_word  word_q[$];
    t_pixel      pixel_q[$];
    t_pixel      got;
    t_pixel      want;

    // line tracer state
    logic        trace_active;
    t_coord      trace_x;
    t_coord      trace_y;
    t_coord      trace_dx;
    t_coord      trace_dy;
    logic        trace_x_down;
    logic        trace_y_down;
    logic        trace_x_major;
    t_err        trace_err;
    t_err        trace_left;
    t_colour     trace_colour;

    bit          word_taken;
    bit          send_hold;
    bit          pixel_taken;
    bit          send_burst;
    bit          recv_burst;
    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned hold_left;
    int unsigned pixels_seen;
    int unsigned quiet_cycles;
    int unsigned errors;

    function automatic t_coord step_coord(input t_coord c, input logic down);
        return down ? t_coord'(c - 1'b1) : t_coord'(c + 1'b1);
    endfunction

    task automatic trace_word(input t_line_word w);
        t_coord major;
        t_coord minor;
        t_pixel p;
        if (w.op == LPS_OP_START) begin
            trace_x       = w.sx;
            trace_y       = w.sy;
            trace_dx      = (w.sx >= w.ex) ? w.sx - w.ex : w.ex - w.sx;
            trace_dy      = (w.sy >= w.ey) ? w.sy - w.ey : w.ey - w.sy;
            trace_x_down  = !(w.ex > w.sx);
            trace_y_down  = !(w.ey > w.sy);
            trace_x_major = trace_dx >= trace_dy;
            major         = trace_x_major ? trace_dx : trace_dy;
            trace_err     = t_err'(major >> 1);
            trace_left    = t_err'(major);
            trace_colour  = {w.red, w.green, w.blue};
            trace_active  = trace_left != 0;
        end else if (!trace_active || trace_left == 0) begin
            trace_active = 1'b0;
        end else begin
            major     = trace_x_major ? trace_dx : trace_dy;
            minor     = trace_x_major ? trace_dy : trace_dx;
            trace_err = trace_err + minor;
            if (trace_err >= major) begin
                trace_err = trace_err - major;
                if (trace_x_major) begin
                    trace_y = step_coord(trace_y, trace_y_down);
                end else begin
                    trace_x = step_coord(trace_x, trace_x_down);
                end
            end
            if (trace_x_major) begin
                trace_x = step_coord(trace_x, trace_x_down);
            end else begin
                trace_y = step_coord(trace_y, trace_y_down);
            end
            trace_left = trace_left - 1'b1;
            if (trace_left == 0) begin
                trace_active = 1'b0;
            end
            p.x      = trace_x;
            p.y      = trace_y;
            p.red    = trace_colour[23:16];
            p.green  = trace_colour[15:8];
            p.blue   = trace_colour[7:0];
            p.is_end = trace_left == 0;
            pixel_q.push_back(p);
        end
    endtask

    task automatic add_start(input t_coord sx, input t_coord sy, input t_coord ex,
                             input t_coord ey, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        t_line_word w;
        w.op    = LPS_OP_START;
        w.sx    = sx;
        w.sy    = sy;
        w.ex    = ex;
        w.ey    = ey;
        w.red   = r;
        w.green = g;
        w.blue  = b;
        word_q.push_back(w);
    endtask

    // tick words carry random payload, which the block must ignore
    task automatic add_ticks(input int n);
        t_line_word w;
        for (int i = 0; i < n; i++) begin
            w.op    = LPS_OP_TICK;
            w.sx    = t_coord'($urandom);
            w.sy    = t_coord'($urandom);
            w.ex    = t_coord'($urandom);
            w.ey    = t_coord'($urandom);
            w.red   = 8'($urandom);
            w.green = 8'($urandom);
            w.blue  = 8'($urandom);
            word_q.push_back(w);
        end
    endtask

    function automatic t_coord nearby(input t_coord c);
        int v;
        v = int'(c) + int'($urandom_range(0, 30)) - 15;
        if (v < 0) begin
            v = 0;
        end
        if (v > (1 << CoordBits) - 1) begin
            v = (1 << CoordBits) - 1;
        end
        return t_coord'(v);
    endfunction

    // sampling side: trace accepted words, check pixels, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                trace_word(word_q.pop_front());
                word_taken = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.x      = o_m_tdata[0 +: CoordBits];
                got.y      = o_m_tdata[CoordBits +: CoordBits];
                got.red    = o_m_tdata[2*CoordBits +: 8];
                got.green  = o_m_tdata[2*CoordBits+8 +: 8];
                got.blue   = o_m_tdata[2*CoordBits+16 +: 8];
                got.is_end = o_m_tlast;
                pixel_taken = 1'b1;
                pixels_seen++;
                if (pixel_q.size() == 0) begin
                    $error("pixel with none expected: x %0d y %0d", got.x, got.y);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got.x != want.x) begin
                        $error("pixel_x: expected %0d, got %0d", want.x, got.x);
                        errors++;
                    end
                    if (got.y != want.y) begin
                        $error("pixel_y: expected %0d, got %0d", want.y, got.y);
                        errors++;
                    end
                    if (got.red != want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, got.red);
                        errors++;
                    end
                    if (got.green != want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, got.green);
                        errors++;
                    end
                    if (got.blue != want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                        errors++;
                    end
                    if (got.is_end != want.is_end) begin
                        $error("last_pixel: expected %0d, got %0d", want.is_end, got.is_end);
                        errors++;
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // word driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // a word on offer that was not taken stays on the bus
            send_hold = i_s_tvalid && !word_taken;
            if (word_taken) begin
                word_taken = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                send_wait = send_burst ? 0 : $urandom_range(0, 19);
            end
            if (send_hold) begin
                i_s_tvalid <= 1'b1;
            end else if (send_wait > 0) begin
                send_wait--;
                i_s_tvalid <= 1'b0;
            end else if (word_q.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= word_q[0].op;
                i_s_tdata  <= {word_q[0].blue, word_q[0].green, word_q[0].red,
                               word_q[0].ey, word_q[0].ex, word_q[0].sy, word_q[0].sx};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // pixel receiver, with two long hold-offs to back the block up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pixel_taken) begin
                pixel_taken = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_wait = recv_burst ? 0 : $urandom_range(0, 19);
                if (pixels_seen == 200 || pixels_seen == 800) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned dx;
        int unsigned dy;
        int          ticks;
        t_coord      sx;
        t_coord      sy;
        t_coord      ex;
        t_coord      ey;

        trace_active  = 1'b0;
        trace_x       = '0;
        trace_y       = '0;
        trace_dx      = '0;
        trace_dy      = '0;
        trace_x_down  = 1'b0;
        trace_y_down  = 1'b0;
        trace_x_major = 1'b0;
        trace_err     = '0;
        trace_left    = '0;
        trace_colour  = '0;

        // tick with no line, then a zero-length line
        add_ticks(1);
        add_start(12'd0, 12'd0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
        add_ticks(1);
        // short falling x-major line from the top corner, run past its end
        add_start(12'hFFF, 12'hFFF, 12'hFFC, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
        add_ticks(4);
        // full diagonal, cut off by a full anti-diagonal
        add_start(12'h000, 12'h000, 12'hFFF, 12'hFFF, 8'h00, 8'hFF, 8'h00);
        add_ticks(2);
        add_start(12'h000, 12'hFFF, 12'hFFF, 12'h000, 8'hFF, 8'h00, 8'h00);
        add_ticks(1);
        // steep y-major line drawn to the end
        add_start(12'd100, 12'd200, 12'd103, 12'd210, 8'h00, 8'h00, 8'hFF);
        add_ticks(11);

        while (word_q.size() < 1550) begin
            pick = $urandom_range(0, 99);
            sx   = t_coord'($urandom);
            sy   = t_coord'($urandom);
            if (pick < 80) begin
                if ($urandom_range(0, 19) == 0) begin
                    ex = t_coord'($urandom);
                    ey = t_coord'($urandom);
                end else begin
                    ex = nearby(sx);
                    ey = nearby(sy);
                end
                dx  = (sx >= ex) ? sx - ex : ex - sx;
                dy  = (sy >= ey) ? sy - ey : ey - sy;
                len = (dx >= dy) ? dx : dy;
                add_start(sx, sy, ex, ey, 8'($urandom), 8'($urandom), 8'($urandom));
                if (len > 40) begin
                    ticks = $urandom_range(0, 40);
                end else if ($urandom_range(0, 5) == 0) begin
                    ticks = $urandom_range(0, len);
                end else begin
                    ticks = len + $urandom_range(0, 2);
                end
                add_ticks(ticks);
            end else if (pick < 90) begin
                add_ticks($urandom_range(1, 3));
            end else begin
                add_start(sx, sy, t_coord'($urandom), t_coord'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
                add_ticks($urandom_range(0, 5));
            end
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0) @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
